// File: src/ges_pkg.sv
// Shared constants, types and fixed-point helpers for the linear solver.
package ges_pkg;

    localparam int MAX_ORDER = 8;
    localparam int NUM_COLS  = MAX_ORDER + 1;
    localparam int MAT_DEPTH = MAX_ORDER * NUM_COLS;
    localparam int ADDR_W    = $clog2(MAT_DEPTH);
    localparam int ROW_W     = 3;
    localparam int COL_W     = 4;
    localparam int ORD_W     = 4;
    localparam int DATA_W    = 32;
    localparam int MAG_W     = 48;

    localparam logic [COL_W-1:0] RHS_COL = COL_W'(MAX_ORDER);
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef logic [ROW_W-1:0]          t_row;
    typedef logic [COL_W-1:0]          t_col;
    typedef logic signed [DATA_W-1:0]  t_q;
    typedef logic [ADDR_W-1:0]         t_addr;

    // Sign plus magnitude back to a saturated Q16.16 word.
    function automatic t_q sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
        t_q res;
        if (neg) begin
            if (mag > MAG_W'(33'h0_8000_0000)) res = Q_MIN;
            else res = t_q'(-$signed({1'b0, mag[DATA_W-1:0]}));
        end else begin
            if (mag > MAG_W'(32'h7fff_ffff)) res = Q_MAX;
            else res = t_q'(mag[DATA_W-1:0]);
        end
        return res;
    endfunction

    // Full product to Q16.16, truncated toward zero.
    function automatic t_q q_scale(input logic signed [2*DATA_W-1:0] p);
        logic [2*DATA_W-1:0] mag;
        mag = p[2*DATA_W-1] ? (2*DATA_W)'(-p) : p;
        return sat_mag(p[2*DATA_W-1], mag[MAG_W+15:16]);
    endfunction

    function automatic t_q q_sub(input t_q a, input t_q b);
        logic signed [DATA_W:0] d;
        t_q res;
        d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (d > $signed({1'b0, Q_MAX})) res = Q_MAX;
        else if (d < $signed({1'b1, Q_MIN})) res = Q_MIN;
        else res = d[DATA_W-1:0];
        return res;
    endfunction

endpackage

// File: src/ges_load_if.sv
// Load channel: one augmented-matrix entry per item.
interface ges_load_if;
    logic                 valid;
    logic                 ready;
    ges_pkg::t_row        row_index;
    ges_pkg::t_col        column_index;
    ges_pkg::t_q          entry_value;
    logic                 load_last;
    modport source (output valid, row_index, column_index, entry_value, load_last,
                    input ready);
    modport sink   (input valid, row_index, column_index, entry_value, load_last,
                    output ready);
endinterface

// File: src/ges_sol_if.sv
// Result channel: one solution element per item.
interface ges_sol_if;
    logic                 valid;
    logic                 ready;
    ges_pkg::t_row        solution_index;
    ges_pkg::t_q          solution_value;
    logic                 singular;
    logic                 result_last;
    modport source (output valid, solution_index, solution_value, singular, result_last,
                    input ready);
    modport sink   (input valid, solution_index, solution_value, singular, result_last,
                    output ready);
endinterface

// File: src/ges_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ges_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: src/ges_div.sv
// Restoring divider: (a * 2^16) / b, truncated toward zero, saturated; one bit a cycle.
module ges_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  ges_pkg::t_q i_a,
    input  ges_pkg::t_q i_b,
    output logic        o_done,
    output ges_pkg::t_q o_q
);
    localparam int MW = ges_pkg::MAG_W;
    localparam int DW = ges_pkg::DATA_W;

    logic               r_busy;
    logic [5:0]         r_cnt;
    logic [MW-1:0]      r_dvd;
    logic [DW:0]        r_rem;
    logic [DW-1:0]      r_dvs;
    logic               r_neg;
    logic               r_zero;
    logic [DW:0]        rem_sh;
    logic [DW:0]        rem_sub;
    logic [DW-1:0]      a_mag;
    logic [DW-1:0]      b_mag;

    assign a_mag   = i_a[DW-1] ? DW'(-i_a) : i_a;
    assign b_mag   = i_b[DW-1] ? DW'(-i_b) : i_b;
    assign rem_sh  = {r_rem[DW-1:0], r_dvd[MW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(MW);
                r_dvd  <= {a_mag, 16'b0};
                r_rem  <= '0;
                r_dvs  <= b_mag;
                r_neg  <= i_a[DW-1] ^ i_b[DW-1];
                r_zero <= (i_b == '0);
            end else if (r_busy) begin
                // quotient bits shift in at the bottom of the dividend register
                if (!rem_sub[DW]) begin
                    r_rem <= rem_sub;
                    r_dvd <= {r_dvd[MW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_dvd <= {r_dvd[MW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_q = r_zero ? '0 : ges_pkg::sat_mag(r_neg, r_dvd);
endmodule

// File: src/gaussian_elimination_solver.sv
// Top level of the Q16.16 dense linear solver (Gaussian elimination, back substitution).
//
// Usage:
//   i_load carries one augmented-matrix entry per item; column 8 is the
//   right-hand side. Loads are taken one a cycle while idle. The item with
//   load_last set writes its entry and starts the solve; i_load.ready stays
//   low until every result of that run has been taken.
//   o_sol then gives the solution elements 0..n-1 in order, result_last on
//   element n-1, or one item with singular set when a column has no
//   non-zero pivot. n is the system_order register (i_cfg_we/i_cfg_data),
//   clamped to 1..8, reset value 3; write it only while idle.
// Timing:
//   The solve runs on one shared multiplier and one bit-serial divider
//   under the sequencer below. Each update of a matrix entry reads both
//   operands, multiplies, scales and writes back; each divide first
//   fetches its operands. Once the solve is done, results leave one a
//   cycle while o_sol.ready is high.
// Reset and stall:
//   Synchronous active-low reset returns to idle, clears the row map to
//   identity and the order to 3. Matrix contents are not cleared. A stall
//   on o_sol holds the current result; nothing is dropped.
module gaussian_elimination_solver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ges_pkg::ORD_W-1:0]  i_cfg_data,
    ges_load_if.sink                   i_load,
    ges_sol_if.source                  o_sol
);
    localparam int MO = ges_pkg::MAX_ORDER;

    typedef enum logic [4:0] {
        S_IDLE, S_PIV_A, S_PIV_B, S_SRCH_A, S_SRCH_B,
        S_F_A, S_F_B, S_F_W,
        S_E_A, S_E_B, S_E_C, S_E_D, S_E_E,
        S_B_A, S_B_B, S_B_C, S_B_D, S_B_E, S_B_F, S_B_DA, S_B_DB, S_B_DW,
        S_OUT, S_SING
    } t_state;

    t_state                r_state;
    logic [ges_pkg::ORD_W-1:0] r_order;
    logic [3:0]            r_n;
    logic [3:0]            r_i;
    logic [3:0]            r_j;
    logic [3:0]            r_k;
    logic [3:0]            r_col;
    ges_pkg::t_row         r_perm [MO];     // logical row -> physical row
    ges_pkg::t_row         r_prow;
    ges_pkg::t_row         r_krow;
    ges_pkg::t_q           r_pvt;
    ges_pkg::t_q           r_f;
    ges_pkg::t_q           r_a;
    ges_pkg::t_q           r_b;
    ges_pkg::t_q           r_m;
    ges_pkg::t_q           r_acc;
    logic signed [63:0]    r_p;
    ges_pkg::t_q           r_sol [MO];

    logic                  ram_we;
    ges_pkg::t_addr        ram_waddr;
    ges_pkg::t_q           ram_wdata;
    ges_pkg::t_addr        ram_raddr;
    ges_pkg::t_q           ram_rdata;
    ges_pkg::t_row         perm_idx;
    ges_pkg::t_row         perm_rd;
    ges_pkg::t_row         sol_idx;
    ges_pkg::t_q           sol_rd;
    logic                  div_start;
    ges_pkg::t_q           div_a;
    ges_pkg::t_q           div_b;
    logic                  div_done;
    ges_pkg::t_q           div_q;
    ges_pkg::t_q           mul_a;
    ges_pkg::t_q           mul_b;
    logic signed [63:0]    mul_p;
    logic                  load_acc;
    logic [3:0]            n_clamp;
    logic [3:0]            col_first;

    function automatic ges_pkg::t_addr mat_addr(input ges_pkg::t_row row,
                                                input ges_pkg::t_col col);
        return ges_pkg::t_addr'({row, 3'b000}) + ges_pkg::t_addr'(row)
             + ges_pkg::t_addr'(col);
    endfunction

    assign load_acc  = i_load.valid && i_load.ready;
    assign n_clamp   = (r_order == 4'd0) ? 4'd1 : (r_order > 4'(MO)) ? 4'(MO) : r_order;
    assign col_first = (r_i + 4'd1 < r_n) ? r_i + 4'd1 : ges_pkg::RHS_COL;

    // single read port on the row map
    always_comb begin
        case (r_state)
            S_IDLE:   perm_idx = i_load.row_index;
            S_PIV_A:  perm_idx = r_i[2:0];
            S_B_A:    perm_idx = r_i[2:0];
            S_SRCH_A: perm_idx = r_j[2:0];
            S_SRCH_B: perm_idx = r_j[2:0];
            default:  perm_idx = r_k[2:0];
        endcase
    end
    assign perm_rd = r_perm[perm_idx];
    assign sol_idx = (r_state == S_OUT) ? r_k[2:0] : r_j[2:0];
    assign sol_rd  = r_sol[sol_idx];

    // one multiplier shared by elimination and back substitution
    assign mul_a = (r_state == S_E_C) ? r_f : ram_rdata;
    assign mul_b = (r_state == S_E_C) ? r_a : sol_rd;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        case (r_state)
            S_PIV_A:  ram_raddr = mat_addr(perm_rd, r_i);
            S_SRCH_A: ram_raddr = mat_addr(perm_rd, r_i);
            S_F_A:    ram_raddr = mat_addr(perm_rd, r_i);
            S_E_A:    ram_raddr = mat_addr(r_prow, r_col);
            S_E_B:    ram_raddr = mat_addr(r_krow, r_col);
            S_B_A:    ram_raddr = mat_addr(perm_rd, ges_pkg::RHS_COL);
            S_B_C:    ram_raddr = mat_addr(r_prow, r_j);
            S_B_DA:   ram_raddr = mat_addr(r_prow, r_i);
            default:  ram_raddr = '0;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = mat_addr(r_krow, r_col);
        ram_wdata = ges_pkg::q_sub(r_b, r_m);
        if (r_state == S_IDLE) begin
            ram_we    = load_acc && (i_load.column_index <= ges_pkg::RHS_COL);
            ram_waddr = mat_addr(perm_rd, i_load.column_index);
            ram_wdata = i_load.entry_value;
        end else if (r_state == S_E_E) begin
            ram_we = 1'b1;
        end
    end

    assign div_start = (r_state == S_F_B) || (r_state == S_B_DB);
    assign div_a     = (r_state == S_F_B) ? ram_rdata : r_acc;
    assign div_b     = (r_state == S_F_B) ? r_pvt : ram_rdata;

    ges_ram #(.WIDTH(ges_pkg::DATA_W), .DEPTH(ges_pkg::MAT_DEPTH)) u_mat (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ges_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_b     (div_b),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= 4'd3;
            for (int r = 0; r < MO; r++) begin
                r_perm[r] <= ges_pkg::t_row'(r);
            end
        end else begin
            if (i_cfg_we) begin
                r_order <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (load_acc && i_load.load_last) begin
                        r_n     <= n_clamp;
                        r_i     <= 4'd0;
                        r_state <= S_PIV_A;
                    end
                end
                // ---- forward elimination: pivot pick ----
                S_PIV_A: begin
                    r_prow  <= perm_rd;
                    r_j     <= r_i + 4'd1;
                    r_state <= S_PIV_B;
                end
                S_PIV_B: begin
                    if (ram_rdata != '0) begin
                        r_pvt <= ram_rdata;
                        r_k   <= r_i + 4'd1;
                        if (r_i + 4'd1 < r_n) r_state <= S_F_A;
                        else begin
                            r_i     <= r_n - 4'd1;
                            r_state <= S_B_A;
                        end
                    end else if (r_j < r_n) begin
                        r_state <= S_SRCH_A;
                    end else begin
                        r_state <= S_SING;
                    end
                end
                S_SRCH_A: r_state <= S_SRCH_B;
                S_SRCH_B: begin
                    if (ram_rdata != '0) begin
                        // swap rows by exchanging map entries
                        r_pvt                <= ram_rdata;
                        r_perm[r_i[2:0]]     <= perm_rd;
                        r_perm[r_j[2:0]]     <= r_prow;
                        r_prow               <= perm_rd;
                        r_k                  <= r_i + 4'd1;
                        if (r_i + 4'd1 < r_n) r_state <= S_F_A;
                        else begin
                            r_i     <= r_n - 4'd1;
                            r_state <= S_B_A;
                        end
                    end else if (r_j + 4'd1 < r_n) begin
                        r_j     <= r_j + 4'd1;
                        r_state <= S_SRCH_A;
                    end else begin
                        r_state <= S_SING;
                    end
                end
                // ---- row factor ----
                S_F_A: begin
                    r_krow  <= perm_rd;
                    r_state <= S_F_B;
                end
                S_F_B: r_state <= S_F_W;
                S_F_W: begin
                    if (div_done) begin
                        r_f     <= div_q;
                        r_col   <= col_first;
                        r_state <= S_E_A;
                    end
                end
                // ---- entry update: A[k][c] -= f * A[i][c] ----
                S_E_A: r_state <= S_E_B;
                S_E_B: begin
                    r_a     <= ram_rdata;
                    r_state <= S_E_C;
                end
                S_E_C: begin
                    r_b     <= ram_rdata;
                    r_p     <= mul_p;
                    r_state <= S_E_D;
                end
                S_E_D: begin
                    r_m     <= ges_pkg::q_scale(r_p);
                    r_state <= S_E_E;
                end
                S_E_E: begin
                    if (r_col != ges_pkg::RHS_COL) begin
                        r_col   <= (r_col + 4'd1 < r_n) ? r_col + 4'd1 : ges_pkg::RHS_COL;
                        r_state <= S_E_A;
                    end else if (r_k + 4'd1 < r_n) begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_F_A;
                    end else begin
                        r_i     <= r_i + 4'd1;
                        r_state <= S_PIV_A;
                    end
                end
                // ---- back substitution ----
                S_B_A: begin
                    r_prow  <= perm_rd;
                    r_j     <= r_n - 4'd1;
                    r_state <= S_B_B;
                end
                S_B_B: begin
                    r_acc   <= ram_rdata;
                    r_state <= (r_j > r_i) ? S_B_C : S_B_DA;
                end
                S_B_C: r_state <= S_B_D;
                S_B_D: begin
                    r_p     <= mul_p;
                    r_state <= S_B_E;
                end
                S_B_E: begin
                    r_m     <= ges_pkg::q_scale(r_p);
                    r_state <= S_B_F;
                end
                S_B_F: begin
                    r_acc   <= ges_pkg::q_sub(r_acc, r_m);
                    r_j     <= r_j - 4'd1;
                    r_state <= (r_j - 4'd1 > r_i) ? S_B_C : S_B_DA;
                end
                S_B_DA: r_state <= S_B_DB;
                S_B_DB: r_state <= S_B_DW;
                S_B_DW: begin
                    if (div_done) begin
                        r_sol[r_i[2:0]] <= div_q;
                        if (r_i == 4'd0) begin
                            r_k     <= 4'd0;
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= r_i - 4'd1;
                            r_state <= S_B_A;
                        end
                    end
                end
                // ---- results ----
                S_OUT: begin
                    if (o_sol.ready) begin
                        if (r_k + 4'd1 == r_n) r_state <= S_IDLE;
                        else r_k <= r_k + 4'd1;
                    end
                end
                S_SING: begin
                    if (o_sol.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_load.ready         = (r_state == S_IDLE);
    assign o_sol.valid          = (r_state == S_OUT) || (r_state == S_SING);
    assign o_sol.singular       = (r_state == S_SING);
    assign o_sol.solution_index = (r_state == S_OUT) ? r_k[2:0] : '0;
    assign o_sol.solution_value = (r_state == S_OUT) ? sol_rd : '0;
    assign o_sol.result_last    = (r_state == S_SING) || (r_k + 4'd1 == r_n);
endmodule

// File: src/ges_checker.sv
// Port-level checks for the linear solver, bound to the top level.
module ges_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_load_ready,
    input logic        i_sol_valid,
    input logic        i_sol_ready,
    input logic [2:0]  i_sol_index,
    input logic [31:0] i_sol_value,
    input logic        i_sol_singular,
    input logic        i_sol_last
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sol_valid && !i_sol_ready |=> i_sol_valid && $stable(i_sol_index)
            && $stable(i_sol_value) && $stable(i_sol_last))
        else $error("result changed under stall");

    // no loads are taken while results are pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load_ready && i_sol_valid))
        else $error("load ready while results pending");

    // a singular report is always the single last item
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sol_valid && i_sol_singular |-> i_sol_last && i_sol_index == 3'd0)
        else $error("singular item not last");

    // results stream without gaps until the last one
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sol_valid && i_sol_ready && !i_sol_last |=> i_sol_valid)
        else $error("gap inside result run");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_sol_valid)
        else $error("result valid after reset");
endmodule

bind gaussian_elimination_solver ges_checker u_ges_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_load_ready   (i_load.ready),
    .i_sol_valid    (o_sol.valid),
    .i_sol_ready    (o_sol.ready),
    .i_sol_index    (o_sol.solution_index),
    .i_sol_value    (o_sol.solution_value),
    .i_sol_singular (o_sol.singular),
    .i_sol_last     (o_sol.result_last)
);
